/* rtl/pfc_pkg.sv */
package pfc_pkg;

   localparam logic [3:0] FMT_RGBA32F     = 4'd0;
   localparam logic [3:0] FMT_RGBA16F     = 4'd1;
   localparam logic [3:0] FMT_RGBA8       = 4'd2;
   localparam logic [3:0] FMT_RGBA8_UNORM = 4'd3;
   localparam logic [3:0] FMT_R32F        = 4'd4;
   localparam logic [3:0] FMT_R16F        = 4'd5;
   localparam logic [3:0] FMT_R8_UNORM    = 4'd6;
   localparam logic [3:0] FMT_R8_UINT     = 4'd7;
   localparam logic [3:0] FMT_A2RGB10     = 4'd8;
   localparam logic [3:0] FMT_D32S8       = 4'd9;

   localparam logic [3:0] CSR_PIXEL_FORMAT = 4'd0;
   localparam logic [3:0] CSR_STENCIL_ONLY = 4'd1;

   localparam int NUM_LANES = 4;

   typedef enum logic [1:0] {
      K_ZERO,
      K_FULL,
      K_BYTE,
      K_CALC
   } kind_type;

   // value = man * 2^(expo - 150), strictly inside (0,1) when kind is K_CALC
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  val;
      logic [23:0] man;
      logic [7:0]  expo;
   } op_type;

   typedef struct packed {
      logic   valid;
      logic   last;
      op_type [NUM_LANES-1:0] op;
   } stage_type;

   function automatic op_type mk_op(input kind_type k, input logic [7:0] v);
      op_type o;
      o.kind = k;
      o.val  = v;
      o.man  = '0;
      o.expo = '0;
      return o;
   endfunction

   function automatic op_type f32_op(input logic [31:0] w, input logic nan_full);
      op_type o;
      o = mk_op(K_CALC, 8'd0);
      if (w[30:23] == 8'hFF && w[22:0] != '0) begin
         o.kind = nan_full ? K_FULL : K_ZERO;
      end else if (w[31] || w[30:23] == 8'd0) begin
         o.kind = K_ZERO;
      end else if (w[30:23] >= 8'd127) begin
         o.kind = K_FULL;
      end else begin
         o.man  = {1'b1, w[22:0]};
         o.expo = w[30:23];
      end
      return o;
   endfunction

   function automatic op_type f16_op(input logic [15:0] h, input logic nan_full);
      op_type o;
      o = mk_op(K_CALC, 8'd0);
      if (h[14:10] == 5'h1F && h[9:0] != '0) begin
         o.kind = nan_full ? K_FULL : K_ZERO;
      end else if (h[15] || h[14:10] == 5'd0) begin
         o.kind = K_ZERO;
      end else if (h[14:10] >= 5'd15) begin
         o.kind = K_FULL;
      end else begin
         o.man  = {1'b1, h[9:0], 13'd0};
         o.expo = {3'd0, h[14:10]} + 8'd112;
      end
      return o;
   endfunction

   // f/1023 is f repeated every 10 bits; sticky is always set so no ties
   function automatic op_type ten_op(input logic [9:0] f);
      op_type      o;
      logic [3:0]  lz;
      logic        found;
      logic [39:0] rep;
      o     = mk_op(K_CALC, 8'd0);
      lz    = 4'd0;
      found = 1'b0;
      for (int i = 9; i >= 0; i--) begin
         if (!found && f[i]) begin
            found = 1'b1;
            lz    = 4'(9 - i);
         end
      end
      rep = {f, f, f, f} << lz;
      if (f == 10'd0) begin
         o.kind = K_ZERO;
      end else if (f == 10'h3FF) begin
         o.kind = K_FULL;
      end else begin
         o.man  = rep[39:16] + {23'd0, rep[15]};
         o.expo = 8'd126 - {4'd0, lz};
      end
      return o;
   endfunction

endpackage

/* rtl/pfc_if.sv */
interface pfc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] channel_0;
   logic [31:0] channel_1;
   logic [31:0] channel_2;
   logic [31:0] channel_3;
   logic        last_pixel;
   modport source (output valid, channel_0, channel_1, channel_2, channel_3, last_pixel,
                   input ready);
   modport sink   (input valid, channel_0, channel_1, channel_2, channel_3, last_pixel,
                   output ready);
endinterface

interface pfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_out;
   modport source (output valid, red, green, blue, alpha, last_out, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_out, output ready);
endinterface

interface pfc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/pfc_decode.sv */
module pfc_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [31:0]         ch0,
   input  logic [31:0]         ch1,
   input  logic [31:0]         ch2,
   input  logic [31:0]         ch3,
   input  logic                in_last,
   input  logic [3:0]          pixel_format,
   input  logic                stencil_only,
   output pfc_pkg::stage_type  s1
);
   import pfc_pkg::*;

   stage_type s1_ff;
   stage_type s1_in;
   op_type    r_op;

   always_comb begin
      s1_in.valid = in_valid;
      s1_in.last  = in_last;
      r_op        = mk_op(K_ZERO, 8'd0);
      for (int i = 0; i < NUM_LANES; i++) begin
         s1_in.op[i] = mk_op(K_ZERO, 8'd0);
      end
      unique case (pixel_format)
         FMT_RGBA32F: begin
            s1_in.op[0] = f32_op(ch0, 1'b1);
            s1_in.op[1] = f32_op(ch1, 1'b1);
            s1_in.op[2] = f32_op(ch2, 1'b1);
            s1_in.op[3] = f32_op(ch3, 1'b1);
         end
         FMT_RGBA16F: begin
            s1_in.op[0] = f16_op(ch0[15:0], 1'b1);
            s1_in.op[1] = f16_op(ch1[15:0], 1'b1);
            s1_in.op[2] = f16_op(ch2[15:0], 1'b1);
            s1_in.op[3] = f16_op(ch3[15:0], 1'b1);
         end
         FMT_RGBA8, FMT_RGBA8_UNORM: begin
            s1_in.op[0] = mk_op(K_BYTE, ch0[7:0]);
            s1_in.op[1] = mk_op(K_BYTE, ch0[15:8]);
            s1_in.op[2] = mk_op(K_BYTE, ch0[23:16]);
            s1_in.op[3] = (pixel_format == FMT_RGBA8) ? mk_op(K_BYTE, ch0[31:24])
                                                      : mk_op(K_FULL, 8'd0);
         end
         FMT_R32F, FMT_R16F, FMT_R8_UNORM, FMT_R8_UINT, FMT_D32S8: begin
            if (pixel_format == FMT_R32F) begin
               r_op = f32_op(ch0, 1'b0);
            end else if (pixel_format == FMT_R16F) begin
               r_op = f16_op(ch0[15:0], 1'b0);
            end else if (pixel_format == FMT_D32S8) begin
               if (stencil_only) begin
                  r_op = mk_op((ch0[7:0] != 8'd0) ? K_FULL : K_ZERO, 8'd0);
               end else begin
                  r_op = f32_op(ch0, 1'b0);
               end
            end else begin
               r_op = mk_op(K_BYTE, ch0[7:0]);
            end
            s1_in.op[0] = r_op;
            s1_in.op[1] = r_op;
            s1_in.op[2] = r_op;
            s1_in.op[3] = mk_op(K_FULL, 8'd0);
         end
         FMT_A2RGB10: begin
            s1_in.op[0] = ten_op(ch0[29:20]);
            s1_in.op[1] = ten_op(ch0[19:10]);
            s1_in.op[2] = ten_op(ch0[9:0]);
            s1_in.op[3] = mk_op(K_FULL, 8'd0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff.valid <= s1_in.valid;
      end
      if (adv) begin
         s1_ff.last <= s1_in.last;
         s1_ff.op   <= s1_in.op;
      end
   end

   assign s1 = s1_ff;

endmodule

/* rtl/pfc_lane.sv */
module pfc_lane (
   input  logic            clock,
   input  logic            adv,
   input  pfc_pkg::op_type op,
   output logic [7:0]      byte_out
);
   import pfc_pkg::*;

   kind_type    kind_ff;
   logic [7:0]  val_ff;
   logic [7:0]  expo_ff;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   logic [23:0] keep;
   logic        rnd;
   logic        sticky;
   logic        lsb;
   logic [24:0] mr;
   logic [7:0]  sh;
   logic [24:0] shifted;

   assign prod_in = {op.man, 8'd0} - {8'd0, op.man};

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff <= op.kind;
         val_ff  <= op.val;
         expo_ff <= op.expo;
         prod_ff <= prod_in;
      end
   end

   // round product to float32 precision, then truncate to integer
   always_comb begin
      if (prod_ff[31]) begin
         keep   = prod_ff[31:8];
         rnd    = prod_ff[7];
         sticky = |prod_ff[6:0];
      end else begin
         keep   = prod_ff[30:7];
         rnd    = prod_ff[6];
         sticky = |prod_ff[5:0];
      end
      lsb     = keep[0];
      mr      = {1'b0, keep} + {24'd0, rnd & (sticky | lsb)};
      sh      = 8'd142 - expo_ff + {7'd0, ~prod_ff[31]};
      shifted = mr >> sh[4:0];
      unique case (kind_ff)
         K_ZERO:  byte_out = 8'd0;
         K_FULL:  byte_out = 8'hFF;
         K_BYTE:  byte_out = val_ff;
         K_CALC:  byte_out = (sh > 8'd24) ? 8'd0 : shifted[7:0];
         default: byte_out = 8'd0;
      endcase
   end

endmodule

/* rtl/pixel_format_to_rgba8_converter_core.sv */
// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    channel_0..3, last_pixel
// rsp_bus   out  valid/ready    red, green, blue, alpha, last_out
// csr_bus   in   valid/ready    index, data (0 pixel_format, 1 stencil_only)
//
// One pixel per cycle unless the output stalls; stages: decode, multiply by 255, round/truncate.
// Synchronous reset clears valids; pixel_format and stencil_only reset to 0.
// The whole pipeline stalls together while a result waits; req_bus.ready is
// low only when the output register is full and not being taken.
module pixel_format_to_rgba8_converter_core (
   input logic      clock,
   input logic      reset,
   pfc_req_if.sink  req_bus,
   pfc_rsp_if.source rsp_bus,
   pfc_csr_if.sink  csr_bus
);
   import pfc_pkg::*;

   logic [3:0]  pixel_format_ff;
   logic        stencil_only_ff;
   logic        adv;
   stage_type   s1;
   logic        v2_ff;
   logic        last2_ff;
   logic [7:0]  lane_byte [NUM_LANES];
   logic        out_valid_ff;
   logic        out_last_ff;
   logic [7:0]  out_byte_ff [NUM_LANES];

   assign adv           = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RGBA32F;
         stencil_only_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_PIXEL_FORMAT) begin
            pixel_format_ff <= csr_bus.data[3:0];
         end else if (csr_bus.index == CSR_STENCIL_ONLY) begin
            stencil_only_ff <= csr_bus.data[0];
         end
      end
   end

   pfc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_bus.valid),
      .ch0          (req_bus.channel_0),
      .ch1          (req_bus.channel_1),
      .ch2          (req_bus.channel_2),
      .ch3          (req_bus.channel_3),
      .in_last      (req_bus.last_pixel),
      .pixel_format (pixel_format_ff),
      .stencil_only (stencil_only_ff),
      .s1           (s1)
   );

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      pfc_lane u_lane (
         .clock    (clock),
         .adv      (adv),
         .op       (s1.op[g]),
         .byte_out (lane_byte[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v2_ff        <= s1.valid;
         out_valid_ff <= v2_ff;
      end
      if (adv) begin
         last2_ff    <= s1.last;
         out_last_ff <= last2_ff;
         out_byte_ff <= lane_byte;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.red      = out_byte_ff[0];
   assign rsp_bus.green    = out_byte_ff[1];
   assign rsp_bus.blue     = out_byte_ff[2];
   assign rsp_bus.alpha    = out_byte_ff[3];
   assign rsp_bus.last_out = out_last_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1.valid)
      else $error("accepted request not in decode stage");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && adv) |=> rsp_bus.valid)
      else $error("pipeline lost a request");

endmodule

/* tb/pixel_format_to_rgba8_converter_core_tb.sv */
`timescale 1ns / 1ps

module pixel_format_to_rgba8_converter_core_tb;
   import pfc_pkg::*;

   typedef struct {
      logic [31:0] ch0;
      logic [31:0] ch1;
      logic [31:0] ch2;
      logic [31:0] ch3;
      logic        last;
   } pixel_type;

   typedef struct {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
      logic       last;
   } rgba_type;

   logic clock;
   logic reset;

   pfc_req_if req_bus();
   pfc_rsp_if rsp_bus();
   pfc_csr_if csr_bus();

   pixel_format_to_rgba8_converter_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_type pending_pixels[$];
   rgba_type  expected_rgba[$];
   logic [3:0] cur_format;
   logic       cur_stencil;
   int  errors;
   int  pixels_sent;
   int  pixels_checked;
   bit  req_acc;
   bit  calm;
   bit  hold_done;
   int  hold_cnt;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // round to 24 significant bits, nearest even; st marks nonzero bits below x
   function automatic void round24(input logic [63:0] x, input bit st,
                                   output logic [63:0] q, output int sh);
      int k;
      logic [63:0] rem;
      logic [63:0] half;
      k = 0;
      for (int i = 0; i < 64; i++) if (x[i]) k = i;
      if (k <= 23) begin
         q  = x;
         sh = 0;
      end else begin
         sh   = k - 23;
         q    = x >> sh;
         rem  = x & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && (st || q[0]))) q = q + 64'd1;
      end
   endfunction

   // trunc(float32(m * 2^e * 255)), saturated at 255
   function automatic logic [7:0] times255(input logic [63:0] m, input int e);
      logic [63:0] q;
      logic [63:0] v;
      int sh;
      int s;
      round24(m * 64'd255, 1'b0, q, sh);
      s = sh + e;
      if (s >= 0) v = (s > 8) ? 64'd255 : (q << s);
      else if (s <= -64) v = 64'd0;
      else v = q >> (-s);
      return (v >= 64'd255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] f32_byte(input logic [31:0] w, input bit nan_full);
      logic [63:0] m;
      int e;
      if (w[30:23] == 8'hFF && w[22:0] != 0) return nan_full ? 8'd255 : 8'd0;
      if (w[31] || w[30:0] == 0) return 8'd0;
      if (w[30:23] >= 8'd127) return 8'd255;
      if (w[30:23] == 8'd0) begin
         m = {41'd0, w[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, w[22:0]};
         e = int'(w[30:23]) - 150;
      end
      return times255(m, e);
   endfunction

   function automatic logic [31:0] half_bits(input logic [15:0] h);
      logic [9:0] man;
      logic [7:0] ex;
      if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      if (h[14:10] == 5'd0) begin
         if (h[9:0] == 0) return {h[15], 31'd0};
         man = h[9:0];
         ex  = 8'd113;
         while (!man[9]) begin
            man = man << 1;
            ex  = ex - 8'd1;
         end
         man = man << 1;
         return {h[15], ex - 8'd1, man, 13'd0};
      end
      return {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
   endfunction

   function automatic logic [7:0] ten_byte(input logic [9:0] f);
      logic [63:0] num;
      logic [63:0] q;
      int sh;
      if (f == 0) return 8'd0;
      num = {54'd0, f} << 45;
      round24(num / 64'd1023, (num % 64'd1023) != 0, q, sh);
      return times255(q, sh - 45);
   endfunction

   function automatic rgba_type convert_pixel(input pixel_type p);
      rgba_type o;
      o = '{8'd0, 8'd0, 8'd0, 8'd0, p.last};
      case (cur_format)
         FMT_RGBA32F: begin
            o.r = f32_byte(p.ch0, 1'b1);
            o.g = f32_byte(p.ch1, 1'b1);
            o.b = f32_byte(p.ch2, 1'b1);
            o.a = f32_byte(p.ch3, 1'b1);
         end
         FMT_RGBA16F: begin
            o.r = f32_byte(half_bits(p.ch0[15:0]), 1'b1);
            o.g = f32_byte(half_bits(p.ch1[15:0]), 1'b1);
            o.b = f32_byte(half_bits(p.ch2[15:0]), 1'b1);
            o.a = f32_byte(half_bits(p.ch3[15:0]), 1'b1);
         end
         FMT_RGBA8, FMT_RGBA8_UNORM: begin
            o.r = p.ch0[7:0];
            o.g = p.ch0[15:8];
            o.b = p.ch0[23:16];
            o.a = (cur_format == FMT_RGBA8) ? p.ch0[31:24] : 8'hFF;
         end
         FMT_R32F, FMT_R16F, FMT_R8_UNORM, FMT_R8_UINT, FMT_D32S8: begin
            if (cur_format == FMT_R32F) o.r = f32_byte(p.ch0, 1'b0);
            else if (cur_format == FMT_R16F) o.r = f32_byte(half_bits(p.ch0[15:0]), 1'b0);
            else if (cur_format == FMT_D32S8)
               o.r = cur_stencil ? ((p.ch0[7:0] != 0) ? 8'hFF : 8'h00)
                                 : f32_byte(p.ch0, 1'b0);
            else o.r = p.ch0[7:0];
            o.g = o.r;
            o.b = o.r;
            o.a = 8'hFF;
         end
         FMT_A2RGB10: begin
            o.r = ten_byte(p.ch0[29:20]);
            o.g = ten_byte(p.ch0[19:10]);
            o.b = ten_byte(p.ch0[9:0]);
            o.a = 8'hFF;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [31:0] special_word(input int i);
      logic [31:0] sp[16];
      sp = '{32'h0000_0000, 32'h3F80_0000, 32'h7FC0_0000, 32'hFF80_0000,
             32'h7F80_0000, 32'h8000_0000, 32'h3F7F_FFFF, 32'h0000_0001,
             32'hFFFF_FFFF, 32'h0000_3C00, 32'hFFFF_7E00, 32'h0000_3BFF,
             32'h0000_0001, 32'h0000_FC00, 32'h437F_0000, 32'h3B80_8081};
      return sp[i % 16];
   endfunction

   function automatic logic [9:0] pick10();
      case ($urandom_range(2))
         0: return 10'd0;
         1: return 10'h3FF;
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(6))
         0: w = special_word($urandom_range(15));
         1: w = {1'b0, 8'($urandom_range(126, 100)), 23'($urandom)};
         2: w[15:0] = {1'b0, 5'($urandom_range(14)), 10'($urandom)};
         3: w[15:0] = {1'b0, 5'($urandom_range(30, 15)), 10'($urandom)};
         4: w[29:0] = {pick10(), pick10(), pick10()};
         5: w[7:0] = ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(3));
         default: ;
      endcase
      return w;
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.ch0  = rand_word();
      p.ch1  = rand_word();
      p.ch2  = rand_word();
      p.ch3  = rand_word();
      p.last = ($urandom_range(7) == 0);
      return p;
   endfunction

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_rgba.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_PIXEL_FORMAT) cur_format = value[3:0];
      else if (idx == CSR_STENCIL_ONLY) cur_stencil = value[0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // request side bookkeeping and response check
   always @(posedge clock) begin
      rgba_type e;
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_rgba.push_back(convert_pixel(pending_pixels[0]));
         void'(pending_pixels.pop_front());
         pixels_sent++;
         req_acc = 1'b1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rgba.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel r=%h g=%h b=%h a=%h", $time,
                     rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.alpha);
         end else begin
            e = expected_rgba.pop_front();
            if (rsp_bus.red !== e.r || rsp_bus.green !== e.g || rsp_bus.blue !== e.b ||
                rsp_bus.alpha !== e.a || rsp_bus.last_out !== e.last) begin
               errors++;
               $display("%0t: fmt %0d exp %h %h %h %h last %b, got %h %h %h %h last %b",
                        $time, cur_format, e.r, e.g, e.b, e.a, e.last, rsp_bus.red,
                        rsp_bus.green, rsp_bus.blue, rsp_bus.alpha, rsp_bus.last_out);
            end
         end
         pixels_checked++;
         if (pixels_checked == 600 && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = 300;
         end
      end
   end

   always @(negedge clock) begin
      pixel_type p;
      if (!reset && !(req_bus.valid && !req_acc)) begin
         if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
            p = pending_pixels[0];
            req_bus.valid      <= 1'b1;
            req_bus.channel_0  <= p.ch0;
            req_bus.channel_1  <= p.ch1;
            req_bus.channel_2  <= p.ch2;
            req_bus.channel_3  <= p.ch3;
            req_bus.last_pixel <= p.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      req_acc = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   initial begin
      #2_000_000;
      $display("** pixel_format_to_rgba8_converter_core: FAILED **");
      $finish;
   end

   initial begin
      logic [3:0] formats[14];
      bit         stencils[14];
      pixel_type  p;
      formats  = '{FMT_RGBA32F, FMT_RGBA16F, FMT_RGBA8, FMT_RGBA8_UNORM, FMT_R32F,
                   FMT_R16F, FMT_R8_UNORM, FMT_R8_UINT, FMT_A2RGB10, FMT_D32S8,
                   FMT_D32S8, 4'd12, 4'd15, FMT_RGBA32F};
      stencils = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1};
      errors = 0;
      pixels_sent = 0;
      pixels_checked = 0;
      req_acc = 1'b0;
      calm = 1'b0;
      hold_done = 1'b0;
      hold_cnt = 0;
      cur_format = FMT_RGBA32F;
      cur_stencil = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.channel_0 = '0;
      req_bus.channel_1 = '0;
      req_bus.channel_2 = '0;
      req_bus.channel_3 = '0;
      req_bus.last_pixel = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_PIXEL_FORMAT;
      csr_bus.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // float extremes, NaN, infinities, signed zero, halves and denormals
      for (int i = 0; i < 16; i++) begin
         p.ch0 = special_word(i);
         p.ch1 = special_word(i + 3);
         p.ch2 = special_word(i + 7);
         p.ch3 = special_word(i + 11);
         p.last = i[0];
         pending_pixels.push_back(p);
      end
      wait_idle();

      for (int ph = 0; ph < 14; ph++) begin
         csr_write(CSR_PIXEL_FORMAT, {28'($urandom), formats[ph]});
         csr_write(CSR_STENCIL_ONLY, {31'($urandom), stencils[ph]});
         calm = (ph == 5);
         for (int i = 0; i < 135; i++) pending_pixels.push_back(rand_pixel());
         wait_idle();
      end
      calm = 1'b0;

      $display("%0d pixels checked across all pixel formats incl. unused codes,", pixels_checked);
      $display("with random stalls on both sides and one long output hold-off.");
      if (errors == 0 && pixels_checked == pixels_sent)
         $display("** pixel_format_to_rgba8_converter_core: PASSED **");
      else
         $display("** pixel_format_to_rgba8_converter_core: FAILED **");
      $finish;
   end

endmodule
